[sv/xild_pkg.sv]
// shared types, constants and opcode classification functions
package xild_pkg;

   localparam int MAX_PREFIXES = 14;
   localparam int FIFO_DEPTH   = 2;

   typedef enum logic [2:0] {
      PH_PREFIX = 3'd0,
      PH_MAP    = 3'd1,
      PH_MODRM  = 3'd2,
      PH_SIB    = 3'd3,
      PH_TRAIL  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      MAP_ONE  = 2'd0,
      MAP_0F   = 2'd1,
      MAP_0F38 = 2'd2,
      MAP_0F3A = 2'd3
   } map_type;

   // byte as seen by the classifier, with the long_mode bit captured beside it
   typedef struct packed {
      logic [7:0] instr_byte;
      logic       long_mode;
   } byte_req_type;

   function automatic logic is_legacy(input logic [7:0] b);
      logic r;
      case (b)
         8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65, 8'h66,
         8'h67: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] full_imm(input logic w, input logic osz);
      return w ? 4'd8 : (osz ? 4'd2 : 4'd4);
   endfunction

   function automatic logic [3:0] one_imm(input logic [7:0] b, input logic w,
                                          input logic osz, input logic asz);
      logic [3:0] hi;
      logic [3:0] lo;
      logic [3:0] r;
      logic       imm8_tab;
      logic       imm32_tab;
      hi = b[7:4];
      lo = b[3:0];
      case (b)
         8'h6A, 8'h6B, 8'h80, 8'h82, 8'h83, 8'hA8, 8'hC0, 8'hC1, 8'hC6, 8'hCD,
         8'hD4, 8'hD5, 8'hEB: imm8_tab = 1'b1;
         default: imm8_tab = 1'b0;
      endcase
      case (b)
         8'h68, 8'h69, 8'h81, 8'hA9, 8'hC7, 8'hE8, 8'hE9: imm32_tab = 1'b1;
         default: imm32_tab = 1'b0;
      endcase
      if ((hi == 4'hE && lo < 4'd8) || (hi == 4'hB && lo < 4'd8) || hi == 4'd7 ||
          (hi < 4'd4 && (lo == 4'd4 || lo == 4'hC)) || imm8_tab)
         r = 4'd1;
      else if (b == 8'hC2 || b == 8'hCA)
         r = 4'd2;
      else if (b == 8'hC8)
         r = 4'd3;
      else if ((hi < 4'd4 && (lo == 4'd5 || lo == 4'hD)) || (hi == 4'hB && lo >= 4'd8) ||
               imm32_tab)
         r = full_imm(w, osz);
      else if (hi == 4'hA && lo < 4'd4)
         r = w ? 4'd8 : (asz ? 4'd2 : 4'd4);
      else if (b == 8'hEA || b == 8'h9A)
         r = osz ? 4'd4 : 4'd6;
      else
         r = 4'd0;
      return r;
   endfunction

   function automatic logic one_has_modrm(input logic [7:0] b);
      logic [3:0] hi;
      logic [3:0] lo;
      logic       t;
      hi = b[7:4];
      lo = b[3:0];
      case (b)
         8'h62, 8'h63, 8'h69, 8'h6B, 8'hC0, 8'hC1, 8'hC4, 8'hC5, 8'hC6, 8'hC7,
         8'hD0, 8'hD1, 8'hD2, 8'hD3, 8'hF6, 8'hF7, 8'hFE, 8'hFF: t = 1'b1;
         default: t = 1'b0;
      endcase
      return t || (hi < 4'd4 && (lo < 4'd4 || (lo >= 4'd8 && lo < 4'hC))) ||
             hi == 4'd8 || (hi == 4'hD && lo >= 4'd8);
   endfunction

   function automatic logic [3:0] two_imm(input logic [7:0] b);
      logic [3:0] hi;
      logic [3:0] lo;
      logic [3:0] r;
      hi = b[7:4];
      lo = b[3:0];
      if (hi == 4'd8)
         r = 4'd4;
      else if ((hi == 4'd7 && lo < 4'd4) || b == 8'hA4 || b == 8'hC2 ||
               (b > 8'hC3 && b <= 8'hC6) || b == 8'hBA || b == 8'hAC)
         r = 4'd1;
      else
         r = 4'd0;
      return r;
   endfunction

   function automatic logic two_has_modrm(input logic [7:0] b);
      logic [3:0] hi;
      logic [3:0] lo;
      logic       t;
      hi = b[7:4];
      lo = b[3:0];
      case (b)
         8'h0D, 8'hA3, 8'hA4, 8'hA5, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF: t = 1'b1;
         default: t = 1'b0;
      endcase
      return t || (hi != 4'd3 && hi > 4'd0 && hi < 4'd7) || b >= 8'hD0 ||
             (hi == 4'd7 && lo != 4'd7) || hi == 4'd9 || hi == 4'hB ||
             (hi == 4'hC && lo < 4'd8) || (hi == 4'd0 && lo < 4'd4);
   endfunction

endpackage

[sv/xild_front.sv]
// input side: takes request bytes and the mode bit into a short queue
module xild_front
   import xild_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_instr_byte,
   input  logic         long_mode,
   output logic         q_valid,
   output byte_req_type q_data,
   input  logic         q_pop
);
   localparam int PW = $clog2(FIFO_DEPTH);

   byte_req_type       mem_ff [FIFO_DEPTH];
   logic [PW-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]        cnt_ff, cnt_in;
   logic               push;

   assign req_stall = (cnt_ff == (PW+1)'(FIFO_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign q_data    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ((wr_ff == PW'(FIFO_DEPTH-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = (q_pop && q_valid) ? ((rd_ff == PW'(FIFO_DEPTH-1)) ? '0 : rd_ff + 1'b1)
                                  : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= '{instr_byte: req_instr_byte, long_mode: long_mode};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

[sv/xild_back.sv]
// decode side: walks prefixes, opcode, modrm, sib and trailing bytes
module xild_back
   import xild_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  byte_req_type q_data,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [4:0]   rsp_length
);
   phase_type  phase_ff, phase_in;
   logic [4:0] seen_ff, seen_in;
   logic [3:0] pfx_ff, pfx_in;
   logic       osz_ff, osz_in, asz_ff, asz_in, w_ff, w_in;
   map_type    map_ff, map_in;
   logic [7:0] opc_ff, opc_in, modrm_ff, modrm_in;
   logic [3:0] imm_ff, imm_in;
   logic [4:0] trail_ff, trail_in;
   logic       vld_ff, vld_in;
   logic [4:0] len_ff, len_in;

   logic       step, done, has_m;
   logic [3:0] immv, immx;
   logic [4:0] disp, tot;
   logic [7:0] b;
   logic [1:0] md;

   assign q_pop      = q_valid && (!vld_ff || !rsp_stall);
   assign step       = q_pop;
   assign rsp_valid  = vld_ff;
   assign rsp_length = len_ff;
   assign b          = q_data.instr_byte;
   assign md         = b[7:6];

   always_comb begin
      phase_in = phase_ff; seen_in = seen_ff + 5'd1; pfx_in = pfx_ff;
      osz_in = osz_ff; asz_in = asz_ff; w_in = w_ff; map_in = map_ff;
      opc_in = opc_ff; modrm_in = modrm_ff; imm_in = imm_ff; trail_in = trail_ff;
      done = 1'b0; has_m = 1'b0; immv = 4'd0; immx = imm_ff; disp = 5'd0; tot = 5'd0;
      unique case (phase_ff)
         PH_MAP: begin
            if (b == 8'h38 || b == 8'h3A) begin
               map_in = (b == 8'h3A) ? MAP_0F3A : MAP_0F38;
               has_m  = 1'b1;
               immv   = (b == 8'h3A) ? 4'd1 : 4'd0;
            end else begin
               opc_in = b;
               has_m  = two_has_modrm(b);
               immv   = two_imm(b);
            end
            imm_in = immv;
            if (has_m) phase_in = PH_MODRM;
            else if (immv == 4'd0) done = 1'b1;
            else begin
               trail_in = {1'b0, immv};
               phase_in = PH_TRAIL;
            end
         end
         PH_MODRM: begin
            modrm_in = b;
            if (map_ff == MAP_ONE && (opc_ff == 8'hF6 || opc_ff == 8'hF7) && b[5:4] == 2'd0)
               immx = (opc_ff == 8'hF6) ? 4'd1 : full_imm(w_ff, osz_ff);
            imm_in = immx;
            if (asz_ff)
               disp = (md == 2'd1) ? 5'd1 : (md == 2'd2) ? 5'd2 :
                      (md == 2'd0 && b[2:0] == 3'd6) ? 5'd2 : 5'd0;
            else
               disp = (md == 2'd1) ? 5'd1 : (md == 2'd2) ? 5'd4 :
                      (md == 2'd0 && b[2:0] == 3'd5) ? 5'd4 : 5'd0;
            tot = disp + {1'b0, immx};
            if (!asz_ff && md != 2'd3 && b[2:0] == 3'd4) phase_in = PH_SIB;
            else if (tot == 5'd0) done = 1'b1;
            else begin
               trail_in = tot;
               phase_in = PH_TRAIL;
            end
         end
         PH_SIB: begin
            disp = (modrm_ff[7:6] == 2'd1) ? 5'd1 : (modrm_ff[7:6] == 2'd2) ? 5'd4 :
                   (b[2:0] == 3'd5) ? 5'd4 : 5'd0;
            tot = disp + {1'b0, imm_ff};
            if (tot == 5'd0) done = 1'b1;
            else begin
               trail_in = tot;
               phase_in = PH_TRAIL;
            end
         end
         PH_TRAIL: begin
            trail_in = trail_ff - 5'd1;
            if (trail_in == 5'd0) done = 1'b1;
         end
         default: begin
            if (pfx_ff < 4'(MAX_PREFIXES) &&
                (is_legacy(b) || (q_data.long_mode && b[7:4] == 4'd4))) begin
               pfx_in = pfx_ff + 4'd1;
               if (b == 8'h66) osz_in = 1'b1;
               else if (b == 8'h67) asz_in = 1'b1;
               else if (b[7:4] == 4'd4 && b[3]) w_in = 1'b1;
               phase_in = PH_PREFIX;
            end else if (b == 8'h0F) begin
               map_in   = MAP_0F;
               phase_in = PH_MAP;
            end else begin
               map_in = MAP_ONE;
               opc_in = b;
               has_m  = one_has_modrm(b);
               immv   = one_imm(b, w_ff, osz_ff, asz_ff);
               imm_in = immv;
               if (has_m) phase_in = PH_MODRM;
               else if (immv == 4'd0) done = 1'b1;
               else begin
                  trail_in = {1'b0, immv};
                  phase_in = PH_TRAIL;
               end
            end
         end
      endcase
   end

   always_comb begin
      vld_in = vld_ff && rsp_stall;
      len_in = len_ff;
      if (step && done) begin
         vld_in = 1'b1;
         len_in = seen_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      if (step) begin
         opc_ff   <= done ? 8'd0 : opc_in;
         modrm_ff <= done ? 8'd0 : modrm_in;
         imm_ff   <= done ? 4'd0 : imm_in;
         trail_ff <= done ? 5'd0 : trail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0; phase_ff <= PH_PREFIX; seen_ff <= '0; pfx_ff <= '0;
         osz_ff <= 1'b0; asz_ff <= 1'b0; w_ff <= 1'b0; map_ff <= MAP_ONE;
      end else begin
         vld_ff <= vld_in;
         if (step) begin
            if (done) begin
               phase_ff <= PH_PREFIX; seen_ff <= '0; pfx_ff <= '0;
               osz_ff <= 1'b0; asz_ff <= 1'b0; w_ff <= 1'b0; map_ff <= MAP_ONE;
            end else begin
               phase_ff <= phase_in; seen_ff <= seen_in; pfx_ff <= pfx_in;
               osz_ff <= osz_in; asz_ff <= asz_in; w_ff <= w_in; map_ff <= map_in;
            end
         end
      end
   end
endmodule

[sv/x86_instruction_length_decoder_top.sv]
// top level of the x86 instruction length decoder
//  channel   dir  handshake          payload
//  req       in   req_valid/stall    req_instr_byte[7:0]
//  rsp       out  rsp_valid/stall    rsp_length[4:0]
//  csr       in   csr_write_enable   csr_write_data (long_mode)
// one byte per cycle sustained unless rsp stalls; a byte passes the queue, then the registered length
// the two-entry byte queue decouples intake from the decode state machine
// synchronous active-high reset clears state and long_mode
// a stalled rsp holds its length; further bytes fill the queue then stall req
module x86_instruction_length_decoder_top
   import xild_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_instr_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [4:0] rsp_length,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);
   logic         long_mode_ff;
   logic         q_valid, q_pop;
   byte_req_type q_data;

   always_ff @(posedge clock) begin
      if (reset) long_mode_ff <= 1'b0;
      else if (csr_write_enable) long_mode_ff <= csr_write_data;
   end

   xild_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_instr_byte,
      .long_mode(long_mode_ff), .q_valid, .q_data, .q_pop
   );

   xild_back u_back (
      .clock, .reset, .q_valid, .q_data, .q_pop, .rsp_valid, .rsp_stall, .rsp_length
   );
endmodule

[sv/xild_checker.sv]
// port-level checks for the length decoder
module xild_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [4:0] rsp_length
);
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_length != 5'd0) else $error("zero length");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_length)) else $error("rsp changed");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("rsp after reset");
   a_no_stall_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(req_valid) |-> !req_stall) else $error("stall while empty");
endmodule

bind x86_instruction_length_decoder_top xild_checker u_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_length
);
